@@ hdl/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Types, widths and constants shared by the scheduler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int MAX_PROCS = 32;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam logic [15:0] LIMIT_RESET = 16'd100;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  proc_name;
        logic [15:0] arr_tick;
        logic [7:0]  svc_ticks;
    } in_item_t;

    typedef struct packed {
        logic        ran_valid;
        logic [7:0]  ran_name;
        logic        finished;
        logic [15:0] turnaround;
        logic [15:0] response;
        logic [15:0] waiting;
        logic        all_done;
        logic        load_full;
    } out_item_t;

    // One pending process.
    typedef struct packed {
        logic [7:0]  name;
        logic [15:0] arrival;
        logic [7:0]  service;
    } pend_t;

    // One run-queue entry, held in a cell.
    typedef struct packed {
        logic [7:0]  name;
        logic [15:0] arrival;
        logic [7:0]  remaining;
        logic [7:0]  orig_service;
        logic [15:0] start;
        logic        started;
    } run_t;

    // Per-cycle command broadcast along the cell row.
    typedef struct packed {
        logic         append;    // load tail cell with new entry
        logic         run;       // run the selected cell
        logic         remove;    // cells at or above sel take neighbour's value
        logic         cut;       // drop first unstarted and beyond
        logic [IDX_W-1:0] sel;
        logic [CNT_W-1:0] len;
        logic [15:0]  t;
        run_t         new_entry;
    } cell_cmd_t;

endpackage

@@ hdl/round_robin_task_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// Round-robin task scheduler core
// Pending list memory, a row of run-queue cells and a sequencer.
// ----------------------------------------------------------------------------
// A load item passes through the output state only. A tick item passes through
// admission (one pending-list read per cycle), run, post and output states;
// once the admission limit is reached the admission step is replaced by a
// single cut step. The result is held in an output register, and
// the next item is taken only once that register is empty or its result is
// being taken in the same cycle.
module round_robin_task_scheduler_core
    import rrts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ADMIT = 6'b000010,
        ST_CUT   = 6'b000100,
        ST_RUN   = 6'b001000,
        ST_POST  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [15:0]     limit_reg;
    logic [CNT_W-1:0] pcount_reg, admit_reg, qlen_reg;
    logic [IDX_W-1:0] rot_reg;
    logic [15:0]     time_reg;
    out_item_t       res_reg;
    logic            out_valid_reg;
    pend_t           pend_mem [MAX_PROCS];
    pend_t           pend_rd_reg;
    logic            pend_rd_ok_reg;
    logic [IDX_W-1:0] cut_pos;
    logic            cut_found;

    cell_cmd_t cmd;
    run_t      cells [MAX_PROCS];
    run_t      uppers [MAX_PROCS];

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++) begin : g_cell
            if (g == MAX_PROCS - 1) begin : g_top
                assign uppers[g] = cells[g];
            end else begin : g_mid
                assign uppers[g] = cells[g+1];
            end
            rrts_cell u_cell (
                .aclk   (aclk),
                .my_idx (IDX_W'(g)),
                .cmd    (cmd),
                .upper  (uppers[g]),
                .entry  (cells[g])
            );
        end
    endgenerate

    // First never-started entry below the queue length (priority search).
    always_comb begin
        cut_pos   = '0;
        cut_found = 1'b0;
        for (int i = MAX_PROCS - 1; i >= 0; i--) begin
            if (CNT_W'(i) < qlen_reg && !cells[i].started) begin
                cut_pos   = IDX_W'(i);
                cut_found = 1'b1;
            end
        end
    end

    logic can_accept;
    assign can_accept = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign s_ready    = can_accept;
    assign cfg_ready  = 1'b1;
    assign m_valid    = out_valid_reg;
    assign m_data     = res_reg;

    run_t  sel_e;
    logic [7:0]  srv;
    logic [15:0] done_t, tat;
    logic [IDX_W-1:0] rot_eff;
    logic [CNT_W-1:0] qlen_m1;
    assign sel_e   = cells[rot_reg];
    assign done_t  = time_reg + 16'd1;
    assign tat     = done_t - sel_e.arrival;
    assign srv     = (pend_rd_reg.service == 8'd0) ? 8'd1 : pend_rd_reg.service;
    // The pointer may sit past the end after a cut, so it wraps before use.
    assign rot_eff = (CNT_W'(rot_reg) >= qlen_reg) ? '0 : rot_reg;
    assign qlen_m1 = qlen_reg - CNT_W'(1);

    out_item_t first_res;
    always_comb begin
        first_res           = '0;
        first_res.load_full = (s_data.mode == MODE_LOAD)
                              && (pcount_reg >= CNT_W'(MAX_PROCS));
    end

    always_comb begin
        cmd = '0;
        cmd.sel = rot_eff;
        cmd.len = qlen_reg;
        cmd.t   = time_reg;
        cmd.new_entry.name         = pend_rd_reg.name;
        cmd.new_entry.arrival      = pend_rd_reg.arrival;
        cmd.new_entry.remaining    = srv;
        cmd.new_entry.orig_service = srv;
        cmd.new_entry.start        = '0;
        cmd.new_entry.started      = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && can_accept) begin
                    if (s_data.mode == MODE_TICK) begin
                        state_next = (time_reg < limit_reg) ? ST_ADMIT : ST_CUT;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_ADMIT: begin
                // pend_rd_reg holds entry admit_reg when pend_rd_ok_reg.
                if (pend_rd_ok_reg && admit_reg < pcount_reg
                        && qlen_reg < CNT_W'(MAX_PROCS)
                        && pend_rd_reg.arrival <= time_reg) begin
                    cmd.append = 1'b1;
                end else if (pend_rd_ok_reg) begin
                    state_next = ST_RUN;
                end
            end
            ST_CUT:  state_next = ST_RUN;
            ST_RUN: begin
                if (qlen_reg != '0) begin
                    cmd.run = 1'b1;
                end
                state_next = ST_POST;
            end
            ST_POST: begin
                if (res_reg.ran_valid && sel_e.remaining == 8'd0) begin
                    cmd.remove = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Pending memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (can_accept && s_valid && s_data.mode == MODE_LOAD
                && pcount_reg < CNT_W'(MAX_PROCS)) begin
            pend_mem[pcount_reg[IDX_W-1:0]] <= '{s_data.proc_name,
                s_data.arr_tick, s_data.svc_ticks};
        end
        pend_rd_reg <= pend_mem[admit_reg[IDX_W-1:0] + IDX_W'(cmd.append)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            pcount_reg     <= '0;
            admit_reg      <= '0;
            qlen_reg       <= '0;
            rot_reg        <= '0;
            time_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pend_rd_ok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (state_reg == ST_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            pend_rd_ok_reg <= (state_reg == ST_ADMIT) || (state_next == ST_ADMIT);
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && can_accept) begin
                        res_reg <= first_res;
                        if (s_data.mode == MODE_LOAD
                                && pcount_reg < CNT_W'(MAX_PROCS)) begin
                            pcount_reg <= pcount_reg + CNT_W'(1);
                        end
                    end
                end
                ST_ADMIT: begin
                    if (cmd.append) begin
                        qlen_reg  <= qlen_reg + CNT_W'(1);
                        admit_reg <= admit_reg + CNT_W'(1);
                    end
                end
                ST_CUT: begin
                    admit_reg <= pcount_reg;
                    if (cut_found) begin
                        qlen_reg <= CNT_W'(cut_pos);
                    end
                end
                ST_RUN: begin
                    rot_reg <= rot_eff;
                    if (qlen_reg != '0) begin
                        res_reg.ran_valid <= 1'b1;
                        res_reg.ran_name  <= cells[rot_eff].name;
                    end
                end
                ST_POST: begin
                    time_reg <= done_t;
                    if (res_reg.ran_valid) begin
                        if (sel_e.remaining == 8'd0) begin
                            res_reg.finished   <= 1'b1;
                            res_reg.turnaround <= tat;
                            res_reg.response   <= sel_e.start - sel_e.arrival;
                            res_reg.waiting    <= tat - {8'd0, sel_e.orig_service};
                            qlen_reg <= qlen_m1;
                            if (CNT_W'(rot_reg) >= qlen_m1) rot_reg <= '0;
                        end else begin
                            if (CNT_W'(rot_reg) + CNT_W'(1) >= qlen_reg) rot_reg <= '0;
                            else rot_reg <= rot_reg + IDX_W'(1);
                        end
                    end
                end
                ST_OUT: begin
                    res_reg.all_done <= (qlen_reg == '0) && (admit_reg >= pcount_reg);
                end
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/rrts_cell.sv @@
// ----------------------------------------------------------------------------
// Run-queue cell
// Holds one queue entry; shifts down from its upper neighbour on removal.
// ----------------------------------------------------------------------------
module rrts_cell
    import rrts_pkg::*;
(
    input  logic             aclk,
    input  logic [IDX_W-1:0] my_idx,
    input  cell_cmd_t        cmd,
    input  run_t             upper,
    output run_t             entry
);

    run_t entry_reg;
    run_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.append && CNT_W'(my_idx) == cmd.len) begin
            entry_next = cmd.new_entry;
        end else if (cmd.run && my_idx == cmd.sel) begin
            entry_next.remaining = entry_reg.remaining - 8'd1;
            if (!entry_reg.started) begin
                entry_next.started = 1'b1;
                entry_next.start   = cmd.t;
            end
        end else if (cmd.remove && my_idx >= cmd.sel) begin
            entry_next = upper;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ hdl/rrts_checker.sv @@
// ----------------------------------------------------------------------------
// Scheduler port checker
// Checks port behaviour of the scheduler core over time.
// ----------------------------------------------------------------------------
module rrts_checker
    import rrts_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No new item is taken while a result waits.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input ready while result stalled");

    // The cycle after an item is taken shows no result.
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result present straight after accept");

    // Finished implies a process ran.
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.finished |-> m_data.ran_valid)
        else $error("finished without run");

    // All done excludes a run that did not finish.
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.all_done && m_data.ran_valid |-> m_data.finished)
        else $error("all_done with unfinished run");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
